/* rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int BYTE_W                 = 8;
   localparam int COUNT_W                = 4;
   localparam int PAYLOAD_W              = 64;
   localparam int MAX_DATA_BYTES_DEFAULT = 8;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h7E;
   localparam logic [BYTE_W-1:0] PAD_BYTE         = 8'h00;

   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_LEN  = 5'b00010,
      PH_DATA = 5'b00100,
      PH_PAD  = 5'b01000,
      PH_SUM  = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ST_GOOD    = 2'd0,
      ST_LEN_ERR = 2'd1,
      ST_PAD_ERR = 2'd2,
      ST_SUM_ERR = 2'd3
   } status_type;

   typedef struct packed {
      logic                 valid;
      status_type           status;
      logic [COUNT_W-1:0]   length;
      logic [PAYLOAD_W-1:0] payload;
   } result_type;

endpackage

/* rtl/sfr_parser.sv */
// ----------------------------------------------------------------------------
// sfr_parser
// Frame state machine, byte store, byte count and running checksum.
// ----------------------------------------------------------------------------
module sfr_parser
   import sfr_pkg::*;
#(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] start_byte,
   input  logic              in_accept,
   input  logic [BYTE_W-1:0] rx_byte,
   output result_type        result
);

   localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] expected_ff, expected_in;
   logic [COUNT_W-1:0] received_ff, received_in;
   logic [COUNT_W-1:0] received_inc;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  store_ff [MAX_DATA_BYTES];
   logic [BYTE_W-1:0]  store_in [MAX_DATA_BYTES];
   logic [PAYLOAD_W-1:0] packed_payload;

   assign received_inc = received_ff + 4'd1;

   // Bytes at or past the declared length read as zero.
   always_comb begin
      packed_payload = '0;
      for (int i = 0; i < MAX_DATA_BYTES; i++) begin
         if (COUNT_W'(i) < expected_ff) begin
            packed_payload[BYTE_W*i +: BYTE_W] = store_ff[i];
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      sum_in      = sum_ff;
      for (int i = 0; i < MAX_DATA_BYTES; i++) begin
         store_in[i] = store_ff[i];
      end
      result         = '0;
      result.status  = ST_GOOD;

      if (in_accept) begin
         case (phase_ff)
            PH_LEN: begin
               for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                  store_in[i] = '0;
               end
               received_in = '0;
               sum_in      = '0;
               expected_in = '0;
               if (rx_byte == PAD_BYTE) begin
                  phase_in = PH_HUNT;
               end else if (rx_byte > BYTE_W'(MAX_DATA_BYTES)) begin
                  phase_in      = PH_HUNT;
                  result.valid  = 1'b1;
                  result.status = ST_LEN_ERR;
               end else begin
                  expected_in = rx_byte[COUNT_W-1:0];
                  phase_in    = PH_DATA;
               end
            end
            PH_DATA: begin
               store_in[received_ff[IDX_W-1:0]] = rx_byte;
               sum_in      = sum_ff + rx_byte;
               received_in = received_inc;
               if (rx_byte == start_byte) begin
                  phase_in = PH_PAD;
               end else if (received_inc >= expected_ff) begin
                  phase_in = PH_SUM;
               end
            end
            PH_PAD: begin
               if (rx_byte != PAD_BYTE) begin
                  phase_in       = PH_HUNT;
                  result.valid   = 1'b1;
                  result.status  = ST_PAD_ERR;
                  result.length  = expected_ff;
                  result.payload = packed_payload;
               end else if (received_ff < expected_ff) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               phase_in       = PH_HUNT;
               result.valid   = 1'b1;
               result.status  = (rx_byte == sum_ff) ? ST_GOOD : ST_SUM_ERR;
               result.length  = expected_ff;
               result.payload = packed_payload;
            end
            default: begin
               phase_in = (rx_byte == start_byte) ? PH_LEN : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         expected_ff <= '0;
         received_ff <= '0;
         sum_ff      <= '0;
         for (int i = 0; i < MAX_DATA_BYTES; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         phase_ff    <= phase_in;
         expected_ff <= expected_in;
         received_ff <= received_in;
         sum_ff      <= sum_in;
         for (int i = 0; i < MAX_DATA_BYTES; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   // A frame in progress never counts more data bytes than it declared.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_PAD || phase_ff == PH_SUM)
      |-> (received_ff <= expected_ff))
      else $error("received count passed the declared length");

   // Results only come out of the length, pad or checksum phases.
   a_result_phase: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (phase_ff == PH_LEN || phase_ff == PH_PAD || phase_ff == PH_SUM))
      else $error("result produced outside a closing phase");

   // A length error carries neither length nor payload.
   a_len_err_empty: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.status == ST_LEN_ERR)
      |-> (result.length == '0 && result.payload == '0))
      else $error("length error result carries data");

   // Every result returns the parser to hunting.
   a_result_hunt: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> (phase_ff == PH_HUNT))
      else $error("parser did not return to hunting after a result");

endmodule

/* rtl/sfr_out_reg.sv */
// ----------------------------------------------------------------------------
// sfr_out_reg
// Result register that holds a finished frame result until it is taken.
// ----------------------------------------------------------------------------
module sfr_out_reg
   import sfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  result_type           result,
   input  logic                 rsp_stall,
   output logic                 busy,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [COUNT_W-1:0]   rsp_frame_length,
   output logic [PAYLOAD_W-1:0] rsp_payload
);

   logic                 valid_ff, valid_in;
   status_type           status_ff;
   logic [COUNT_W-1:0]   length_ff;
   logic [PAYLOAD_W-1:0] payload_ff;

   // A held result that is not being taken blocks new input; one that is
   // leaving this cycle can be replaced in the same cycle.
   assign busy     = valid_ff && rsp_stall;
   assign valid_in = result.valid || busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         status_ff  <= result.status;
         length_ff  <= result.length;
         payload_ff <= result.payload;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_payload      = payload_ff;

endmodule

/* rtl/stuffed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// stuffed_frame_receiver
// Byte-stuffed frame receiver with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the req_ channel, one per transfer. A frame is
//   the start byte, a length byte, the data bytes (a data byte equal to the
//   start byte is followed by a zero pad), then the checksum byte.
//   Each frame that gets past a nonzero length byte ends in one transfer on
//   the rsp_ channel: status, declared length and packed payload.
//   The csr_ channel writes the start byte; csr_ready is always high.
//   Throughput is one byte per cycle while req_stall is low. A result is
//   valid on rsp_ in the cycle after the byte that closes the frame, held
//   in the output register. When the receiver stalls a held result,
//   req_stall rises until that result is taken; if it is taken in the same
//   cycle a new byte is still accepted. Reset returns the parser to hunting
//   for a start byte, clears counts, checksum and byte store, empties the
//   output register and sets the start byte to 0x7E.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver
   import sfr_pkg::*;
#(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [COUNT_W-1:0]   rsp_frame_length,
   output logic [PAYLOAD_W-1:0] rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [BYTE_W-1:0]    csr_start_byte
);

   logic [BYTE_W-1:0] start_byte_ff;
   logic              in_accept;
   logic              out_busy;
   result_type        result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
      end else if (csr_valid && csr_ready) begin
         start_byte_ff <= csr_start_byte;
      end
   end

   assign req_stall = out_busy;
   assign in_accept = req_valid && !req_stall;

   sfr_parser #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .start_byte (start_byte_ff),
      .in_accept  (in_accept),
      .rx_byte    (req_rx_byte),
      .result     (result)
   );

   sfr_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .result           (result),
      .rsp_stall        (rsp_stall),
      .busy             (out_busy),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload      (rsp_payload)
   );

endmodule

/* tb/sv/frame_receiver_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_receiver_checker
// Watches the byte, result and start byte channels of the stuffed frame
// receiver, runs its own frame parser on every accepted byte and compares
// each result transfer, field by field, with the oldest predicted frame.
// ----------------------------------------------------------------------------
module frame_receiver_checker
   import sfr_pkg::*;
#(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_status,
   input  logic [COUNT_W-1:0]   rsp_frame_length,
   input  logic [PAYLOAD_W-1:0] rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [BYTE_W-1:0]    csr_start_byte,
   output int                   fail_count,
   output int                   pending
);

   // Parser state, kept apart from the block.
   logic [BYTE_W-1:0]  marker;
   phase_type          rx_phase;
   logic [COUNT_W-1:0] declared_count;
   logic [COUNT_W-1:0] stored_count;
   logic [BYTE_W-1:0]  byte_sum;
   logic [BYTE_W-1:0]  byte_store [8];

   result_type frames_due [$];

   task automatic close_frame(input status_type st, input bit with_data);
      result_type fr;
      fr.valid   = 1'b1;
      fr.status  = st;
      fr.length  = with_data ? declared_count : '0;
      fr.payload = '0;
      if (with_data) begin
         for (int i = 0; i < 8; i++) begin
            if (i < declared_count)
               fr.payload[8*i +: 8] = byte_store[i];
         end
      end
      frames_due.push_back(fr);
      rx_phase = PH_HUNT;
   endtask

   task automatic absorb_byte(input logic [BYTE_W-1:0] b);
      case (rx_phase)
         PH_LEN: begin
            foreach (byte_store[i]) byte_store[i] = '0;
            stored_count   = '0;
            byte_sum       = '0;
            declared_count = '0;
            if (b == '0) begin
               rx_phase = PH_HUNT;
            end else if (b > MAX_DATA_BYTES) begin
               close_frame(ST_LEN_ERR, 1'b0);
            end else begin
               declared_count = b[COUNT_W-1:0];
               rx_phase       = PH_DATA;
            end
         end
         PH_DATA: begin
            byte_store[stored_count[2:0]] = b;
            byte_sum     = byte_sum + b;
            stored_count = stored_count + 1'b1;
            // A data byte that looks like the marker must be followed by a pad.
            if (b == marker)
               rx_phase = PH_PAD;
            else if (stored_count >= declared_count)
               rx_phase = PH_SUM;
         end
         PH_PAD: begin
            if (b != PAD_BYTE)
               close_frame(ST_PAD_ERR, 1'b1);
            else
               rx_phase = (stored_count < declared_count) ? PH_DATA : PH_SUM;
         end
         PH_SUM: begin
            close_frame((b == byte_sum) ? ST_GOOD : ST_SUM_ERR, 1'b1);
         end
         default: begin
            rx_phase = (b == marker) ? PH_LEN : PH_HUNT;
         end
      endcase
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      result_type fr;
      if (reset) begin
         marker         = START_BYTE_RESET;
         rx_phase       = PH_HUNT;
         declared_count = '0;
         stored_count   = '0;
         byte_sum       = '0;
         foreach (byte_store[i]) byte_store[i] = '0;
         frames_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            marker = csr_start_byte;
         // Results are matched before this edge's byte can add a new frame.
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               $error("result transfer with no frame outstanding: status %0d length %0d",
                      rsp_status, rsp_frame_length);
               fail_count++;
            end else begin
               fr = frames_due.pop_front();
               if (rsp_status !== fr.status) begin
                  $error("status: expected %0d, got %0d", fr.status, rsp_status);
                  fail_count++;
               end
               if (rsp_frame_length !== fr.length) begin
                  $error("frame_length: expected %0d, got %0d", fr.length, rsp_frame_length);
                  fail_count++;
               end
               if (rsp_payload !== fr.payload) begin
                  $error("payload: expected %h, got %h", fr.payload, rsp_payload);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            absorb_byte(req_rx_byte);
      end
      pending <= frames_due.size();
   end

endmodule

/* tb/sv/tb_stuffed_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stuffed_frame_receiver
// Feeds the stuffed frame receiver with hand-picked frames and then with
// random well-formed, damaged, truncated and noise byte streams under several
// start byte settings, with random gaps and result stalls outside the last
// setting; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_receiver;
   import sfr_pkg::*;

   localparam int BYTES_PER_SETTING = 300;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_status;
   logic [COUNT_W-1:0]   rsp_frame_length;
   logic [PAYLOAD_W-1:0] rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [BYTE_W-1:0]    csr_start_byte;

   int fail_count;
   int pending;
   int byte_count;
   bit calm;
   logic [BYTE_W-1:0] opening_bytes [25];
   logic [BYTE_W-1:0] marker_settings [4];

   stuffed_frame_receiver uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload      (rsp_payload),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_start_byte   (csr_start_byte)
   );

   frame_receiver_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload      (rsp_payload),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_start_byte   (csr_start_byte),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      byte_count++;
      @(negedge clock);
   endtask

   // Waits until every predicted frame has come out, then rewrites the marker.
   task automatic write_start_byte(input logic [BYTE_W-1:0] value);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (4) @(negedge clock);
      csr_valid      <= 1'b1;
      csr_start_byte <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] sb);
      logic [BYTE_W-1:0] frame [$];
      logic [BYTE_W-1:0] len_byte;
      logic [BYTE_W-1:0] d;
      logic [BYTE_W-1:0] sum;
      int  kind;
      int  bad_at;
      bit  bad_pad;
      bit  bad_sum;
      bit  stopped;
      kind    = $urandom_range(0, 99);
      bad_pad = (kind >= 10 && kind < 18);
      bad_sum = (kind >= 18 && kind < 26);
      stopped = 1'b0;
      sum     = '0;
      if (kind < 5)
         len_byte = '0;
      else if (kind < 10)
         len_byte = BYTE_W'($urandom_range(9, 255));
      else if ($urandom_range(0, 3) == 0)
         len_byte = 8'd8;
      else
         len_byte = BYTE_W'($urandom_range(1, 8));
      frame.push_back(sb);
      frame.push_back(len_byte);
      if (len_byte >= 1 && len_byte <= 8) begin
         bad_at = bad_pad ? int'($urandom_range(0, len_byte - 1)) : -1;
         for (int i = 0; i < len_byte; i++) begin
            d = (i == bad_at || $urandom_range(0, 3) == 0) ? sb : BYTE_W'($urandom);
            frame.push_back(d);
            sum = sum + d;
            if (d == sb) begin
               if (i == bad_at) begin
                  frame.push_back(BYTE_W'($urandom_range(1, 255)));
                  stopped = 1'b1;
                  break;
               end
               frame.push_back(PAD_BYTE);
            end
         end
         if (!stopped)
            frame.push_back(bad_sum ? BYTE_W'(sum + $urandom_range(1, 255)) : sum);
      end
      // A few frames are cut short; what follows is then taken as their tail.
      if (kind >= 26 && kind < 30 && frame.size() > 2)
         frame = frame[0 : $urandom_range(1, frame.size() - 2)];
      foreach (frame[i]) send_byte(frame[i]);
   endtask

   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_rx_byte    = '0;
      csr_valid      = 1'b0;
      csr_start_byte = '0;
      byte_count     = 0;
      calm           = 1'b0;
      // Noise, zero length, two oversize lengths, a one-byte frame of zero,
      // a stuffed frame, a bad pad and a bad checksum, all with the reset marker.
      opening_bytes = '{8'h55, 8'h7E, 8'h00, 8'h7E, 8'hFF, 8'h7E, 8'h09,
                        8'h7E, 8'h01, 8'h00, 8'h00,
                        8'h7E, 8'h02, 8'h7E, 8'h00, 8'h11, 8'h8F,
                        8'h7E, 8'h01, 8'h7E, 8'h05,
                        8'h7E, 8'h01, 8'h12, 8'h13};
      marker_settings = '{8'h00, 8'hFF, BYTE_W'($urandom_range(1, 254)), START_BYTE_RESET};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
      foreach (marker_settings[s]) begin
         write_start_byte(marker_settings[s]);
         if (s == 3)
            calm = 1'b1;
         byte_count = 0;
         while (byte_count < BYTES_PER_SETTING) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
            end else begin
               send_frame(marker_settings[s]);
            end
         end
      end
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/sfr_pkg.sv
rtl/sfr_parser.sv
rtl/sfr_out_reg.sv
rtl/stuffed_frame_receiver.sv
tb/sv/frame_receiver_checker.sv
tb/sv/tb_stuffed_frame_receiver.sv
